FILE: hw/rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and word types for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
   localparam logic             CMD_GET   = 1'b0;
   localparam logic             CMD_PUT   = 1'b1;
   localparam logic [VAL_W-1:0] MISS_DATA = '1;

   typedef struct packed {
      logic                    command;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic                    found;
      logic signed [VAL_W-1:0] data;
   } rsp_word_type;

endpackage

FILE: hw/rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        word
//  req      in   valid / stall    command, key, value
//  rsp      out  valid / stall    found, data
//  csr      in   valid / ready    capacity (5 bits)
//
//  One word per clock unless rsp is stalled; requests pass the input, then the
//  result register. Key compare and age update over all entries set the rate.
//  Reset clears valid bits, ages and occupancy; capacity returns to 16.
//  A stalled rsp holds its word; req stalls only while both registers hold a
//  word and rsp is stalled.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic signed [lkvc_pkg::KEY_W-1:0]   req_key,
   input  logic signed [lkvc_pkg::VAL_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic signed [lkvc_pkg::VAL_W-1:0]   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]          csr_data
);
   import lkvc_pkg::*;

   req_word_type in_word, cur_word;
   rsp_word_type result, out_word;
   logic         process, out_free;

   assign in_word.command = req_command;
   assign in_word.key     = req_key;
   assign in_word.value   = req_value;
   assign csr_ready       = 1'b1;
   assign rsp_found       = out_word.found;
   assign rsp_data        = out_word.data;

   lkvc_req_stage u_req (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (in_word),
      .out_free  (out_free),
      .process   (process),
      .word      (cur_word)
   );

   lkvc_store u_store (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .process   (process),
      .word      (cur_word),
      .result    (result)
   );

   lkvc_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .process   (process),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (out_word)
   );

endmodule

FILE: hw/rtl/lkvc_req_stage.sv
// ----------------------------------------------------------------------------
// lkvc_req_stage
// Input register: holds one request word until the core can process it.
// ----------------------------------------------------------------------------
module lkvc_req_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lkvc_pkg::req_word_type req_word,
   input  logic                  out_free,
   output logic                  process,
   output lkvc_pkg::req_word_type word
);
   import lkvc_pkg::*;

   logic         valid_ff, valid_in;
   req_word_type word_ff;
   logic         accept;

   assign req_stall = valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign process   = valid_ff && out_free;
   assign word      = word_ff;
   assign valid_in  = accept || (valid_ff && !process);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

endmodule

FILE: hw/rtl/lkvc_store.sv
// ----------------------------------------------------------------------------
// lkvc_store
// Entry store with parallel key match, recency ages and LRU replacement.
// ----------------------------------------------------------------------------
module lkvc_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic [lkvc_pkg::CAP_W-1:0]   csr_data,
   input  logic                         process,
   input  lkvc_pkg::req_word_type       word,
   output lkvc_pkg::rsp_word_type       result
);
   import lkvc_pkg::*;

   logic [KEY_W-1:0] key_ff   [ENTRIES];
   logic [VAL_W-1:0] value_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0] age_ff [ENTRIES];
   logic [IDX_W-1:0] age_in [ENTRIES];
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CAP_W-1:0] cap_ff;

   logic [CNT_W-1:0]   cap_eff;
   logic [ENTRIES-1:0] match, victim, valid_ev, free_vec, slot_oh;
   logic [ENTRIES-1:0] key_we, val_we;
   logic               hit, is_put, do_touch, do_insert, do_evict;
   logic [IDX_W-1:0]   hit_age, old_age;
   logic [VAL_W-1:0]   hit_value;

   always_comb begin
      if (32'(cap_ff) > ENTRIES) begin
         cap_eff = CNT_W'(ENTRIES);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end

      old_age   = IDX_W'(occ_ff - CNT_W'(1));
      hit_age   = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == word.key);
         victim[i] = valid_ff[i] && (age_ff[i] == old_age);
         hit_age   = hit_age | (match[i] ? age_ff[i] : '0);
         hit_value = hit_value | (match[i] ? value_ff[i] : '0);
      end
      hit = |match;

      is_put    = (word.command == CMD_PUT);
      do_touch  = process && hit;
      do_insert = process && is_put && !hit && (cap_eff != '0);
      do_evict  = do_insert && (occ_ff >= cap_eff) && (occ_ff != '0);

      valid_ev = valid_ff & ~(do_evict ? victim : '0);
      free_vec = ~valid_ev;
      slot_oh  = free_vec & (~free_vec + ENTRIES'(1));

      valid_in = valid_ff;
      key_we   = '0;
      val_we   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (do_touch) begin
            if (match[i]) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && (age_ff[i] < hit_age)) begin
               age_in[i] = age_ff[i] + IDX_W'(1);
            end
            val_we[i] = match[i] && is_put;
         end
         if (do_insert) begin
            valid_in[i] = valid_ev[i] | slot_oh[i];
            if (slot_oh[i]) begin
               age_in[i] = '0;
            end else if (valid_ev[i]) begin
               age_in[i] = age_ff[i] + IDX_W'(1);
            end else begin
               age_in[i] = '0;
            end
            key_we[i] = slot_oh[i];
            val_we[i] = slot_oh[i];
         end
      end

      occ_in = occ_ff;
      if (do_insert && (slot_oh != '0) && !do_evict) begin
         occ_in = occ_ff + CNT_W'(1);
      end

      result.found = hit;
      if (is_put) begin
         result.data = word.value;
      end else if (hit) begin
         result.data = hit_value;
      end else begin
         result.data = MISS_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         cap_ff   <= CAP_RESET;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
         end
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (key_we[i]) begin
            key_ff[i] <= word.key;
         end
         if (val_we[i]) begin
            value_ff[i] <= word.value;
         end
      end
   end

endmodule

FILE: hw/rtl/lkvc_rsp_stage.sv
// ----------------------------------------------------------------------------
// lkvc_rsp_stage
// Result register: holds one response word until the consumer takes it.
// ----------------------------------------------------------------------------
module lkvc_rsp_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   process,
   input  lkvc_pkg::rsp_word_type result,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lkvc_pkg::rsp_word_type rsp_word
);
   import lkvc_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   assign out_free  = !valid_ff || !rsp_stall;
   assign valid_in  = process || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         word_ff <= result;
      end
   end

endmodule

FILE: bench/lru_key_value_cache_test.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_test
// Self-checking bench for the LRU key/value cache: a directed table of gets,
// puts and capacity writes, then random traffic over a small key pool in
// several capacity phases, with random request gaps, random response stalls
// and one long response hold-off. Each response word is compared with a local
// LRU model of the cache, or with the expected word of a typed directed row.
// ----------------------------------------------------------------------------
module lru_key_value_cache_test;
   import lkvc_pkg::*;

   localparam int LIMIT     = 300000;
   localparam int POOL_SIZE = 24;
   localparam int HOLD_AT   = 400;
   localparam int HOLD_LEN  = 64;

   typedef enum logic {ROW_REQ, ROW_CAP} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic                    command;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
      bit                      typed;
      logic                    want_found;
      logic signed [VAL_W-1:0] want_data;
   } row_type;

   localparam logic signed [31:0] MIN_W = 32'sh8000_0000;
   localparam logic signed [31:0] MAX_W = 32'sh7fff_ffff;

   row_type directed[] = '{
      '{ROW_REQ, CMD_GET, 32'sd0,        32'sd0,        1'b1, 1'b0, MISS_DATA},
      '{ROW_REQ, CMD_PUT, MIN_W,         MAX_W,         1'b1, 1'b0, MAX_W},
      '{ROW_REQ, CMD_PUT, MAX_W,         MIN_W,         1'b1, 1'b0, MIN_W},
      '{ROW_REQ, CMD_PUT, 32'sd0,        32'sd0,        1'b1, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_PUT, -32'sd1,       -32'sd1,       1'b1, 1'b0, -32'sd1},
      '{ROW_REQ, CMD_GET, MIN_W,         32'sd0,        1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_GET, MAX_W,         32'sd7,        1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_PUT, MIN_W,         32'sh5a5a5a5a, 1'b1, 1'b1, 32'sh5a5a5a5a},
      '{ROW_REQ, CMD_GET, 32'sd12345,    32'sd0,        1'b1, 1'b0, MISS_DATA},
      '{ROW_CAP, CMD_GET, 32'sd0,        32'sd1,        1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_GET, 32'sd0,        32'sd0,        1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_PUT, 32'sd7,        32'sd70,       1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_PUT, 32'sd0,        32'sd3,        1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_GET, -32'sd1,       32'sd0,        1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_GET, MAX_W,         32'sd0,        1'b0, 1'b0, 32'sd0},
      '{ROW_CAP, CMD_GET, 32'sd0,        32'sd0,        1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_PUT, 32'sd99,       32'sd9,        1'b1, 1'b0, 32'sd9},
      '{ROW_REQ, CMD_GET, 32'sd99,       32'sd0,        1'b1, 1'b0, MISS_DATA},
      '{ROW_REQ, CMD_GET, 32'sd0,        32'sd0,        1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_PUT, 32'sd0,        32'sh0f0f0f0f, 1'b1, 1'b1, 32'sh0f0f0f0f},
      '{ROW_CAP, CMD_GET, 32'sd0,        32'sd31,       1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_PUT, 32'sh1234abcd, -32'sd2,       1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_PUT, 32'sd99,       32'sd42,       1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_GET, 32'sh1234abcd, 32'sd0,        1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, CMD_GET, 32'sd99,       32'sd0,        1'b0, 1'b0, 32'sd0},
      '{ROW_CAP, CMD_GET, 32'sd0,        32'sd16,       1'b0, 1'b0, 32'sd0}
   };

   int phase_cap[8] = '{16, 3, 31, 0, 1, 8, 20, 16};
   int phase_len[8] = '{200, 150, 200, 60, 100, 150, 140, 100};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_command = CMD_GET;
   logic signed [KEY_W-1:0] req_key = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_found;
   logic signed [VAL_W-1:0] rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CAP_W-1:0]        csr_data = '0;

   // local copy of the cache
   logic signed [KEY_W-1:0] cache_keys[ENTRIES];
   logic signed [VAL_W-1:0] cache_vals[ENTRIES];
   bit                      cache_live[ENTRIES];
   int                      cache_rank[ENTRIES];
   int                      cache_fill;
   logic [CAP_W-1:0]        cache_cap;

   rsp_word_type            awaited_rsp[$];
   logic signed [KEY_W-1:0] key_pool[POOL_SIZE];
   int                      failures = 0;
   int                      cycle_count = 0;

   lru_key_value_cache uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_key     (req_key),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_found   (rsp_found),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("[lru_key_value_cache] ERROR");
         $finish;
      end
   end

   function automatic void make_recent(input int slot);
      int i;
      for (i = 0; i < ENTRIES; i++)
         if (cache_live[i] && cache_rank[i] < cache_rank[slot])
            cache_rank[i]++;
      cache_rank[slot] = 0;
   endfunction

   function automatic rsp_word_type lookup_and_update(input logic command,
                                                      input logic signed [KEY_W-1:0] key,
                                                      input logic signed [VAL_W-1:0] value);
      rsp_word_type r;
      int           i, hit, limit, victim, slot;
      hit = -1;
      for (i = 0; i < ENTRIES; i++)
         if (hit < 0 && cache_live[i] && cache_keys[i] == key)
            hit = i;
      limit = (cache_cap > ENTRIES) ? ENTRIES : int'(cache_cap);
      r.found = (hit >= 0);
      if (command == CMD_GET) begin
         if (hit >= 0) begin
            r.data = cache_vals[hit];
            make_recent(hit);
         end else begin
            r.data = MISS_DATA;
         end
         return r;
      end
      r.data = value;
      if (hit >= 0) begin
         cache_vals[hit] = value;
         make_recent(hit);
      end else if (limit != 0) begin
         if (cache_fill >= limit) begin
            victim = -1;
            for (i = 0; i < ENTRIES; i++)
               if (cache_live[i] && (victim < 0 || cache_rank[i] > cache_rank[victim]))
                  victim = i;
            if (victim >= 0) begin
               cache_live[victim] = 0;
               cache_rank[victim] = 0;
               cache_fill--;
            end
         end
         slot = -1;
         for (i = 0; i < ENTRIES; i++)
            if (slot < 0 && !cache_live[i])
               slot = i;
         if (slot >= 0) begin
            for (i = 0; i < ENTRIES; i++)
               if (cache_live[i])
                  cache_rank[i]++;
            cache_keys[slot] = key;
            cache_vals[slot] = value;
            cache_live[slot] = 1;
            cache_rank[slot] = 0;
            cache_fill++;
         end
      end
      return r;
   endfunction

   task automatic send_word(input logic command, input logic signed [KEY_W-1:0] key,
                            input logic signed [VAL_W-1:0] value, input bit typed,
                            input logic want_found, input logic signed [VAL_W-1:0] want_data);
      int           gap;
      rsp_word_type predicted;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= command;
      req_key     <= key;
      req_value   <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = lookup_and_update(command, key, value);
      if (typed) begin
         predicted.found = want_found;
         predicted.data  = want_data;
      end
      awaited_rsp.push_back(predicted);
   endtask

   // capacity is written only once every response is back
   task automatic write_capacity(input logic [CAP_W-1:0] capacity);
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= capacity;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cache_cap = capacity;
      csr_valid <= 1'b0;
   endtask

   // response side: random stalls, one long hold-off
   initial begin
      int           stall_cycles;
      int           taken;
      rsp_word_type want;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall_cycles = (taken == HOLD_AT) ? HOLD_LEN : $urandom_range(0, 3);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         if (awaited_rsp.size() == 0) begin
            $error("unexpected rsp word: found %0d data %0d", rsp_found, rsp_data);
            failures++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               failures++;
            end
            if (rsp_data !== want.data) begin
               $error("data: expected %0d, got %0d", want.data, rsp_data);
               failures++;
            end
         end
      end
   end

   initial begin
      int                      i, p, n;
      logic                    command;
      logic signed [KEY_W-1:0] key;
      for (i = 0; i < ENTRIES; i++) begin
         cache_live[i] = 0;
         cache_rank[i] = 0;
         cache_keys[i] = '0;
         cache_vals[i] = '0;
      end
      cache_fill = 0;
      cache_cap  = CAP_RESET;
      for (i = 0; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      key_pool[0] = MIN_W;
      key_pool[1] = MAX_W;
      key_pool[2] = 32'sd0;
      key_pool[3] = -32'sd1;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[r]) begin
         if (directed[r].kind == ROW_CAP)
            write_capacity(directed[r].value[CAP_W-1:0]);
         else
            send_word(directed[r].command, directed[r].key, directed[r].value,
                      directed[r].typed, directed[r].want_found, directed[r].want_data);
      end

      for (p = 0; p < 8; p++) begin
         write_capacity(CAP_W'(phase_cap[p]));
         for (n = 0; n < phase_len[p]; n++) begin
            command = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 15) == 0)
               key = $urandom;
            else
               key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_word(command, key, $urandom, 1'b0, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("[lru_key_value_cache] OK");
      else
         $display("[lru_key_value_cache] ERROR");
      $finish;
   end

endmodule

FILE: lru_key_value_cache.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_req_stage.sv
hw/rtl/lkvc_store.sv
hw/rtl/lkvc_rsp_stage.sv
hw/rtl/lru_key_value_cache.sv
bench/lru_key_value_cache_test.sv
